@@ rtl/lphp_pkg.sv @@
// Shared constants and types for the lidar packet header parser.
`timescale 1ns / 1ps

package lphp_pkg;

    // Header byte values
    localparam logic [7:0] C_SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] C_SYNC_SECOND = 8'h55;

    // Angle limits in 1/64 degree
    localparam logic [14:0] C_WRAP_HIGH = 15'd17280;  // 270 deg
    localparam logic [14:0] C_WRAP_LOW  = 15'd5760;   // 90 deg
    localparam logic [16:0] C_FULL_TURN = 17'd23040;  // 360 deg

    localparam logic [7:0] C_RESET_MAX_COUNT = 8'd80;

    // Result status codes
    localparam logic [1:0] C_ST_OK        = 2'd0;
    localparam logic [1:0] C_ST_BAD_SYNC  = 2'd1;
    localparam logic [1:0] C_ST_CHECK_BIT = 2'd2;
    localparam logic [1:0] C_ST_COUNT     = 2'd3;

    // Divider geometry
    localparam int C_DIV_W     = 32;
    localparam int C_DVSR_W    = 8;
    localparam int C_DIV_CNT_W = $clog2(C_DIV_W);
    localparam int C_STEP_W    = 23;

    typedef struct packed {
        logic                start;
        logic [C_DIV_W-1:0]  dividend;
        logic [C_DVSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [C_DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/lphp_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module lphp_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lphp_pkg::t_div_req i_req,
    output lphp_pkg::t_div_rsp o_rsp
);
    import lphp_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [C_DIV_CNT_W-1:0] r_cnt;
    logic [C_DVSR_W-1:0]    r_rem;
    logic [C_DVSR_W-1:0]    r_dvsr;
    logic [C_DIV_W-1:0]     r_quo;

    logic [C_DVSR_W:0]      n_trial;
    logic                   n_qbit;
    logic [C_DVSR_W:0]      n_diff;

    // remainder stays below the divisor, so the trial fits in one extra bit
    always_comb begin
        n_trial = {r_rem, r_quo[C_DIV_W-1]};
        n_diff  = n_trial - {1'b0, r_dvsr};
        n_qbit  = (n_trial >= {1'b0, r_dvsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dvsr <= i_req.divisor;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= n_qbit ? n_diff[C_DVSR_W-1:0] : n_trial[C_DVSR_W-1:0];
                r_quo <= {r_quo[C_DIV_W-2:0], n_qbit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_DIV_CNT_W'(C_DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ rtl/lidar_packet_header_parser_core.sv @@
// Top level: byte-wise scan packet header parser with a step divider.
`timescale 1ns / 1ps

// Takes the lidar serial stream one byte per transaction and walks the
// 10-byte scan packet header: sync AA 55, type, sample count, first angle
// word, last angle word, checksum word (words little endian). A good header
// yields one result transaction with the decoded fields; a bad second sync
// byte (timestamp marker 66 included), a clear check bit in an angle word or
// a sample count above max_sample_count yields one error transaction with
// every field but status zero, and the parser goes back to hunting for sync.
// Runs of AA hold the sync. On the last header byte the step angle
// (span * 256) / (count - 1) goes to the bit-serial divider, and the
// input is held off (s_axis_tready low) until the result is valid. When
// the angles go backwards outside the 0/360 wrap window, the previous step
// is reused; counts of 0 or 1 give a step of 0, both without the divider.
// s_axis_tready also drops while a result waits and m_axis_tready is low.
// max_sample_count is written via i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce it.

module lidar_packet_header_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: max_sample_count
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // header results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] ring_start, [7:1] scan_freq, [15:8] sample_count,
    // [30:16] first_angle, [45:31] last_angle, [68:46] step_angle,
    // [84:69] packet_checksum, [87:85] zero
    output logic [87:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import lphp_pkg::*;

    typedef enum logic [3:0] {
        S_HUNT,
        S_SYNC,
        S_TYPE,
        S_COUNT,
        S_FIRST_LO,
        S_FIRST_HI,
        S_LAST_LO,
        S_LAST_HI,
        S_CSUM_LO,
        S_CSUM_HI,
        S_DIVIDE
    } t_state;

    t_state r_state;

    // configuration and carried state
    logic [7:0]          r_max_count;
    logic [C_STEP_W-1:0] r_prev_step;

    // header capture
    logic [7:0]  r_type;
    logic [7:0]  r_count;
    logic [6:0]  r_angle_lo;   // bits 7..1 of the current angle low byte
    logic [14:0] r_first;
    logic [14:0] r_last;
    logic [7:0]  r_csum_lo;

    // output register
    logic                r_m_valid;
    logic [1:0]          r_status;
    logic                r_ring;
    logic [6:0]          r_freq;
    logic [7:0]          r_cnt_out;
    logic [14:0]         r_first_out;
    logic [14:0]         r_last_out;
    logic [C_STEP_W-1:0] r_step_out;
    logic [15:0]         r_csum_out;

    logic        n_in_acc;
    logic        n_fwd;
    logic        n_wrap;
    logic [16:0] n_span;
    t_div_req    n_div_req;
    t_div_rsp    w_div_rsp;

    assign s_axis_tready = (r_state != S_DIVIDE) && (!r_m_valid || m_axis_tready);
    assign n_in_acc      = s_axis_tvalid && s_axis_tready;

    // span in two's complement; the wrap formula can go negative, and the
    // divide then works on the 32-bit wrapped value
    always_comb begin
        n_fwd  = (r_last >= r_first);
        n_wrap = (r_first > C_WRAP_HIGH) && (r_last < C_WRAP_LOW);
        if (n_fwd) begin
            n_span = {2'b00, r_last} - {2'b00, r_first};
        end else begin
            n_span = C_FULL_TURN + {2'b00, r_last} - {2'b00, r_first};
        end
        n_div_req.start    = n_in_acc && (r_state == S_CSUM_HI) && (r_count > 8'd1)
                             && (n_fwd || n_wrap);
        n_div_req.dividend = {{7{n_span[16]}}, n_span, 8'h00};
        n_div_req.divisor  = r_count - 8'd1;
    end

    lphp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HUNT;
            r_m_valid   <= 1'b0;
            r_max_count <= C_RESET_MAX_COUNT;
            r_prev_step <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_count <= i_cfg_wr_data;
            end
            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (n_in_acc) begin
                // error result template; fields other than status are zero
                r_ring      <= 1'b0;
                r_freq      <= '0;
                r_cnt_out   <= '0;
                r_first_out <= '0;
                r_last_out  <= '0;
                r_step_out  <= '0;
                r_csum_out  <= '0;

                unique case (r_state) inside
                    S_SYNC: begin
                        if (s_axis_tdata == C_SYNC_SECOND) begin
                            r_state <= S_TYPE;
                        end else if (s_axis_tdata != C_SYNC_FIRST) begin
                            r_state   <= S_HUNT;
                            r_m_valid <= 1'b1;
                            r_status  <= C_ST_BAD_SYNC;
                        end
                    end
                    S_TYPE: begin
                        r_type  <= s_axis_tdata;
                        r_state <= S_COUNT;
                    end
                    S_COUNT: begin
                        r_count <= s_axis_tdata;
                        if (s_axis_tdata > r_max_count) begin
                            r_state   <= S_HUNT;
                            r_m_valid <= 1'b1;
                            r_status  <= C_ST_COUNT;
                        end else begin
                            r_state <= S_FIRST_LO;
                        end
                    end
                    S_FIRST_LO, S_LAST_LO: begin
                        r_angle_lo <= s_axis_tdata[7:1];
                        if (!s_axis_tdata[0]) begin
                            r_state   <= S_HUNT;
                            r_m_valid <= 1'b1;
                            r_status  <= C_ST_CHECK_BIT;
                        end else begin
                            r_state <= (r_state == S_FIRST_LO) ? S_FIRST_HI : S_LAST_HI;
                        end
                    end
                    S_FIRST_HI: begin
                        r_first <= {s_axis_tdata, r_angle_lo};
                        r_state <= S_LAST_LO;
                    end
                    S_LAST_HI: begin
                        r_last  <= {s_axis_tdata, r_angle_lo};
                        r_state <= S_CSUM_LO;
                    end
                    S_CSUM_LO: begin
                        r_csum_lo <= s_axis_tdata;
                        r_state   <= S_CSUM_HI;
                    end
                    S_CSUM_HI: begin
                        r_status    <= C_ST_OK;
                        r_ring      <= r_type[0];
                        r_freq      <= r_type[0] ? r_type[7:1] : 7'd0;
                        r_cnt_out   <= r_count;
                        r_first_out <= r_first;
                        r_last_out  <= r_last;
                        r_csum_out  <= {s_axis_tdata, r_csum_lo};
                        if (n_div_req.start) begin
                            r_state <= S_DIVIDE;
                        end else begin
                            // short count gives zero, backwards span reuses
                            r_step_out <= (r_count > 8'd1) ? r_prev_step : '0;
                            r_m_valid  <= 1'b1;
                            r_state    <= S_HUNT;
                        end
                    end
                    default: begin
                        r_state <= (s_axis_tdata == C_SYNC_FIRST) ? S_SYNC : S_HUNT;
                    end
                endcase
            end else if (r_state == S_DIVIDE && w_div_rsp.done) begin
                r_step_out  <= w_div_rsp.quotient[C_STEP_W-1:0];
                r_prev_step <= w_div_rsp.quotient[C_STEP_W-1:0];
                r_m_valid   <= 1'b1;
                r_state     <= S_HUNT;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {3'b000, r_csum_out, r_step_out, r_last_out, r_first_out,
                            r_cnt_out, r_freq, r_ring};

endmodule

@@ dv/lidar_header_checker.sv @@
// Checker: tracks the byte stream, predicts header results and compares them.
`timescale 1ns / 1ps

module lidar_header_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_byte_valid,
    input  logic        i_byte_ready,
    input  logic [7:0]  i_byte,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [87:0] i_res_data,
    input  logic [1:0]  i_res_status,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results
);
    import lphp_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        ring_start;
        logic [6:0]  scan_freq;
        logic [7:0]  sample_count;
        logic [14:0] first_angle;
        logic [14:0] last_angle;
        logic [22:0] step_angle;
        logic [15:0] checksum;
    } t_hdr_result;

    t_hdr_result expected_hdr_q[$];

    // parser shadow state
    logic [7:0]  max_count;
    logic [3:0]  hdr_pos;
    logic [7:0]  type_reg;
    logic [7:0]  count_reg;
    logic [15:0] first_word;
    logic [7:0]  last_lo;
    logic [15:0] last_word;
    logic [7:0]  csum_lo;
    logic [22:0] prev_step;

    task automatic log_failure(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            log_failure($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                                  o_results, name, got, want));
        end
    endtask

    // error transaction: only status is set, parser goes back to hunting
    task automatic push_error(input logic [1:0] code);
        t_hdr_result r;
        r        = '0;
        r.status = code;
        expected_hdr_q.push_back(r);
        hdr_pos  = 4'd0;
    endtask

    // (span * 256) / (n - 1) in 32-bit unsigned arithmetic, as the divider sees it
    task automatic step_for(input logic [14:0] f, input logic [14:0] l,
                            input logic [7:0] n, output logic [22:0] step);
        logic [31:0] span;
        logic [31:0] quo;
        logic        run_div;
        run_div = 1'b1;
        span    = '0;
        step    = '0;
        if (n < 8'd2) begin
            run_div = 1'b0;
        end else if (l >= f) begin
            span = {17'd0, l} - {17'd0, f};
        end else if (f > C_WRAP_HIGH && l < C_WRAP_LOW) begin
            span = {15'd0, C_FULL_TURN} + {17'd0, l} - {17'd0, f};
        end else begin
            // backwards outside the wrap window: keep the last step
            step    = prev_step;
            run_div = 1'b0;
        end
        if (run_div) begin
            quo       = (span << 8) / {24'd0, n - 8'd1};
            prev_step = quo[22:0];
            step      = prev_step;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b);
        t_hdr_result r;
        case (hdr_pos)
            4'd1: begin
                if (b == C_SYNC_SECOND) begin
                    hdr_pos = 4'd2;
                end else if (b != C_SYNC_FIRST) begin
                    push_error(C_ST_BAD_SYNC);
                end
            end
            4'd2: begin
                type_reg = b;
                hdr_pos  = 4'd3;
            end
            4'd3: begin
                count_reg = b;
                if (b > max_count) begin
                    push_error(C_ST_COUNT);
                end else begin
                    hdr_pos = 4'd4;
                end
            end
            4'd4: begin
                if (!b[0]) begin
                    push_error(C_ST_CHECK_BIT);
                end else begin
                    first_word[7:0] = b;
                    hdr_pos         = 4'd5;
                end
            end
            4'd5: begin
                first_word[15:8] = b;
                hdr_pos          = 4'd6;
            end
            4'd6: begin
                if (!b[0]) begin
                    push_error(C_ST_CHECK_BIT);
                end else begin
                    last_lo = b;
                    hdr_pos = 4'd7;
                end
            end
            4'd7: begin
                last_word = {b, last_lo};
                hdr_pos   = 4'd8;
            end
            4'd8: begin
                csum_lo = b;
                hdr_pos = 4'd9;
            end
            4'd9: begin
                r              = '0;
                r.status       = C_ST_OK;
                r.ring_start   = type_reg[0];
                r.scan_freq    = type_reg[0] ? type_reg[7:1] : 7'd0;
                r.sample_count = count_reg;
                r.first_angle  = first_word[15:1];
                r.last_angle   = last_word[15:1];
                step_for(r.first_angle, r.last_angle, count_reg, r.step_angle);
                r.checksum     = {b, csum_lo};
                expected_hdr_q.push_back(r);
                hdr_pos        = 4'd0;
            end
            default: begin
                // hunting: a sync byte moves on, anything else is dropped
                hdr_pos = (b == C_SYNC_FIRST) ? 4'd1 : 4'd0;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_hdr_result want;
        if (!i_rst_n) begin
            max_count  = C_RESET_MAX_COUNT;
            hdr_pos    = '0;
            type_reg   = '0;
            count_reg  = '0;
            first_word = '0;
            last_lo    = '0;
            last_word  = '0;
            csum_lo    = '0;
            prev_step  = '0;
            expected_hdr_q.delete();
        end else begin
            // results first: an older expectation is always at the front
            if (i_res_valid && i_res_ready) begin
                if (expected_hdr_q.size() == 0) begin
                    log_failure($sformatf("header result with none pending, status %0d",
                                          i_res_status));
                end else begin
                    want = expected_hdr_q.pop_front();
                    check_field("status", 32'(i_res_status), 32'(want.status));
                    check_field("ring_start", 32'(i_res_data[0]), 32'(want.ring_start));
                    check_field("scan_freq", 32'(i_res_data[7:1]), 32'(want.scan_freq));
                    check_field("sample_count", 32'(i_res_data[15:8]),
                                32'(want.sample_count));
                    check_field("first_angle", 32'(i_res_data[30:16]),
                                32'(want.first_angle));
                    check_field("last_angle", 32'(i_res_data[45:31]),
                                32'(want.last_angle));
                    check_field("step_angle", 32'(i_res_data[68:46]),
                                32'(want.step_angle));
                    check_field("packet_checksum", 32'(i_res_data[84:69]),
                                32'(want.checksum));
                    check_field("tdata pad", 32'(i_res_data[87:85]), 32'd0);
                end
                o_results++;
            end
            if (i_byte_valid && i_byte_ready) begin
                predict_byte(i_byte);
            end
            if (i_cfg_wr_en) begin
                max_count = i_cfg_wr_data;
            end
        end
        o_pending <= expected_hdr_q.size();
    end

endmodule

@@ dv/lidar_packet_header_parser_core_test.sv @@
// Testbench top: byte stimulus, stream pacing and verdict for the header parser.
`timescale 1ns / 1ps

module lidar_packet_header_parser_core_test;
    import lphp_pkg::*;

    localparam logic [7:0] C_TS_MARKER  = 8'h66;  // timestamp packet second byte
    localparam int         C_SETTLE     = 40;     // outlasts the divide on the last byte
    localparam int         C_STALL_LIMIT = 4000;  // cycles without any transaction

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [7:0]  i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int fail_count;
    int hdr_pending;
    int hdr_results;

    // pacing: percent of cycles each side sits idle
    int src_idle_pct = 17;
    int snk_idle_pct = 46;

    int         bytes_sent  = 0;
    int         stall_count = 0;
    logic [7:0] cur_max     = C_RESET_MAX_COUNT;
    logic [7:0] mid_max;

    // Short directed stream, reset limit of 80:
    //   extreme noise bytes 00 and FF while hunting,
    //   repeated AA then the timestamp marker -> bad second sync byte,
    //   count 81 -> too many samples,
    //   first angle low byte with check bit clear -> check bit error,
    //   full header: ring start, count at the limit, first angle 32767,
    //   last angle 0 -> wrap window with a negative span, checksum FFFF.
    logic [7:0] directed_bytes[$] = '{
        8'h00, 8'hFF,
        8'hAA, 8'hAA, 8'h66,
        8'hAA, 8'h55, 8'hFF, 8'h51,
        8'hAA, 8'h55, 8'h01, 8'h02, 8'h00,
        8'hAA, 8'h55, 8'h03, 8'h50, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'hFF, 8'hFF
    };

    lidar_packet_header_parser_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lidar_header_checker u_hdr_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte_valid  (s_axis_tvalid),
        .i_byte_ready  (s_axis_tready),
        .i_byte        (s_axis_tdata),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_status  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (hdr_pending),
        .o_results     (hdr_results)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // result side back-pressure, held off during reset
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // stall watchdog: any transaction on either side restarts the count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_count <= 0;
            end else begin
                stall_count <= stall_count + 1;
            end
            if (stall_count >= C_STALL_LIMIT) begin
                $display("Stalled for %0d cycles, %0d header results pending",
                         stall_count, hdr_pending);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // One byte transaction. Valid stays high after the handshake so that a
    // back-to-back byte never lowers and raises it within one time step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // stop sending and wait until every predicted header result came out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (hdr_pending != 0);
    endtask

    // limit changes only with the parser quiet and the divider finished
    task automatic write_max_count(input logic [7:0] v);
        drain_results();
        repeat (C_SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_max = v;
    endtask

    // Mostly complete headers with random content; the rest is line noise,
    // broken sync, clear check bits and counts over the limit.
    task automatic send_random_frame();
        int          pick;
        int          n;
        logic [7:0]  b;
        logic [7:0]  cnt;
        logic [14:0] fa;
        logic [14:0] la;
        logic [15:0] fw;
        logic [15:0] lw;
        logic [15:0] csum;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 16) begin
            b = $urandom_range(0, 1) ? C_TS_MARKER : 8'($urandom_range(0, 255));
            if (b == C_SYNC_SECOND) b = C_TS_MARKER;
            send_byte(C_SYNC_FIRST);
            send_byte(b);
        end else begin
            // mostly within the limit, with a share of 0/1 and of anything
            n = $urandom_range(0, 9);
            if (n < 7) begin
                cnt = 8'($urandom_range(0, cur_max));
            end else if (n < 8) begin
                cnt = 8'($urandom_range(0, 1));
            end else begin
                cnt = 8'($urandom_range(0, 255));
            end
            case ($urandom_range(0, 3))
                0: begin
                    fa = 15'($urandom_range(0, 32767));
                    la = 15'($urandom_range(0, 32767));
                end
                1: begin                        // forward sweep
                    fa = 15'($urandom_range(0, 23039));
                    la = fa + 15'($urandom_range(0, 2000));
                end
                2: begin                        // across 0/360
                    fa = 15'($urandom_range(17281, 32767));
                    la = 15'($urandom_range(0, 5759));
                end
                default: begin                  // backwards, previous step reused
                    fa = 15'($urandom_range(5760, 17280));
                    la = 15'($urandom_range(0, fa - 1));
                end
            endcase
            fw = {fa, 1'b1};
            lw = {la, 1'b1};
            if ($urandom_range(0, 99) < 6) begin
                fw[0] = 1'b0;
            end else if ($urandom_range(0, 99) < 6) begin
                lw[0] = 1'b0;
            end
            csum = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 4) == 0) send_byte(C_SYNC_FIRST);  // sync run
            send_byte(C_SYNC_FIRST);
            send_byte(C_SYNC_SECOND);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(cnt);
            send_byte(fw[7:0]);
            send_byte(fw[15:8]);
            send_byte(lw[7:0]);
            send_byte(lw[15:8]);
            send_byte(csum[7:0]);
            send_byte(csum[15:8]);
        end
    endtask

    task automatic run_random(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) send_random_frame();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender 17 %, receiver 46 %
        foreach (directed_bytes[k]) send_byte(directed_bytes[k]);
        write_max_count(8'd0);      // only a count of 0 gets through
        run_random(40);
        write_max_count(8'd1);
        run_random(40);
        write_max_count(8'd255);
        run_random(230);
        drain_results();            // sender holds off until all results are out
        run_random(100);

        // sender 46 %, receiver 17 %
        drain_results();
        src_idle_pct = 46;
        snk_idle_pct = 17;
        mid_max = 8'($urandom_range(2, 254));
        write_max_count(mid_max);
        run_random(270);

        // no idling on either side
        drain_results();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_max_count(C_RESET_MAX_COUNT);
        run_random(250);

        drain_results();
        repeat (C_SETTLE) @(posedge i_clk);

        $display("Parsed %0d stream bytes into %0d header results under three pacing modes,",
                 bytes_sent, hdr_results);
        $display("with max_sample_count at 80, 0, 1, 255, %0d and back to 80.", mid_max);
        if (fail_count == 0 && hdr_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ lidar_packet_header_parser_core.f @@
rtl/lphp_pkg.sv
rtl/lphp_div.sv
rtl/lidar_packet_header_parser_core.sv
dv/lidar_header_checker.sv
dv/lidar_packet_header_parser_core_test.sv
